/* rtl/kpec_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath link types for the key press
// event classifier. Used by the controller, datapath, top level and testbench; depends on nothing.
package kpec_pkg;

  localparam int RING_DEPTH = 8;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int COUNT_W    = RING_AW + 1;

  localparam int NUM_KEYS   = 4;
  localparam int KEY_W      = 2;
  localparam int TICK_W     = 8;
  localparam int CODE_W     = 3;
  localparam int PEND_SLOTS = 3;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_INJECT = 2'd2;

  // Key positions in the level vector.
  localparam logic [KEY_W-1:0] KEY_SET  = 2'd0;
  localparam logic [KEY_W-1:0] KEY_UP   = 2'd1;
  localparam logic [KEY_W-1:0] KEY_DOWN = 2'd2;
  localparam logic [KEY_W-1:0] KEY_BACK = 2'd3;

  // Event codes.
  localparam logic [CODE_W-1:0] EV_SET         = 3'd0;
  localparam logic [CODE_W-1:0] EV_UP          = 3'd1;
  localparam logic [CODE_W-1:0] EV_DOWN        = 3'd2;
  localparam logic [CODE_W-1:0] EV_SET_LONG    = 3'd3;
  localparam logic [CODE_W-1:0] EV_BACK        = 3'd4;
  localparam logic [CODE_W-1:0] EV_DOWN_REPEAT = 3'd5;
  localparam logic [CODE_W-1:0] EV_UP_REPEAT   = 3'd6;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SHORT_HOLD      = 2'd0;
  localparam logic [1:0] REG_LONG_HOLD       = 2'd1;
  localparam logic [1:0] REG_REPEAT_START    = 2'd2;
  localparam logic [1:0] REG_REPEAT_INTERVAL = 2'd3;

  localparam logic [TICK_W-1:0] SHORT_HOLD_RESET      = 8'd3;
  localparam logic [TICK_W-1:0] LONG_HOLD_RESET       = 8'd10;
  localparam logic [TICK_W-1:0] REPEAT_START_RESET    = 8'd5;
  localparam logic [TICK_W-1:0] REPEAT_INTERVAL_RESET = 8'd2;

  typedef struct packed {
    logic             load_in;
    logic             eval;
    logic             push_pend;
    logic             push_inj;
    logic             pop_rd;
    logic             out_load;
    logic [KEY_W-1:0] key;
  } kpec_cmd_t;

  typedef struct packed {
    logic pend_any;
  } kpec_sts_t;

  function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
    sat_inc = (v == {TICK_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

/* rtl/kpec_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing controller: walks the four keys on a poll tick, drains pending
// events into the ring one per cycle, steps pops and injects and hands results
// to the output register. Depends on kpec_pkg.
module kpec_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [1:0]          op_in,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  kpec_pkg::kpec_sts_t sts,
  output kpec_pkg::kpec_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_PUSH = 3'd2;
  localparam logic [2:0] ST_POP  = 3'd3;
  localparam logic [2:0] ST_INJ  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]                 state, state_next;
  logic [kpec_pkg::KEY_W-1:0] key_idx, key_idx_next;
  logic                       accept;
  logic                       out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next    = state;
    key_idx_next  = key_idx;
    cmd           = '0;
    cmd.key       = key_idx;
    cmd.load_in   = accept;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          key_idx_next = '0;
          case (op_in)
            kpec_pkg::OP_TICK:   state_next = ST_EVAL;
            kpec_pkg::OP_POP:    state_next = ST_POP;
            kpec_pkg::OP_INJECT: state_next = ST_INJ;
            default:             state_next = ST_DONE;
          endcase
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (sts.pend_any) begin
          cmd.push_pend = 1'b1;
        end else if (key_idx == kpec_pkg::KEY_BACK) begin
          state_next = ST_DONE;
        end else begin
          key_idx_next = key_idx + 1'b1;
          state_next   = ST_EVAL;
        end
      end
      ST_POP: begin
        cmd.pop_rd = 1'b1;
        state_next = ST_DONE;
      end
      ST_INJ: begin
        cmd.push_inj = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      key_idx  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      key_idx <= key_idx_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/kpec_dp.sv */
`timescale 1ns / 1ps
// Datapath: configuration registers, per-key hold records, pending event
// slots, the event ring and the output payload register. Depends on kpec_pkg.
module kpec_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  kpec_pkg::kpec_cmd_t                cmd,
  output kpec_pkg::kpec_sts_t                sts,
  input  logic [3:0]                         levels_in,
  input  logic [kpec_pkg::CODE_W-1:0]        inj_in,
  output logic                               out_event_valid,
  output logic [kpec_pkg::CODE_W-1:0]        out_event_code,
  output logic [2:0]                         out_queue_count,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata
);

  localparam int TW = kpec_pkg::TICK_W;
  localparam int CW = kpec_pkg::CODE_W;
  localparam int AW = kpec_pkg::RING_AW;
  localparam int NW = kpec_pkg::COUNT_W;

  logic [TW-1:0] short_hold, long_hold, repeat_start, repeat_interval;

  logic [3:0]    levels;
  logic [CW-1:0] inj_code;

  logic          was_pressed [kpec_pkg::NUM_KEYS];
  logic [TW-1:0] hold_count  [kpec_pkg::NUM_KEYS];
  logic          short_done  [kpec_pkg::NUM_KEYS];
  logic          long_done   [kpec_pkg::NUM_KEYS];
  logic [TW-1:0] repeat_count[kpec_pkg::NUM_KEYS];

  logic [kpec_pkg::PEND_SLOTS-1:0] pend_valid;
  logic [CW-1:0]                   pend_code[kpec_pkg::PEND_SLOTS];

  logic [CW-1:0] ring_mem[kpec_pkg::RING_DEPTH];
  logic [AW-1:0] wr_pos, rd_pos;
  logic [CW-1:0] rd_data;
  logic          res_valid;

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      short_hold      <= kpec_pkg::SHORT_HOLD_RESET;
      long_hold       <= kpec_pkg::LONG_HOLD_RESET;
      repeat_start    <= kpec_pkg::REPEAT_START_RESET;
      repeat_interval <= kpec_pkg::REPEAT_INTERVAL_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        kpec_pkg::REG_SHORT_HOLD:      short_hold      <= pwdata[TW-1:0];
        kpec_pkg::REG_LONG_HOLD:       long_hold       <= pwdata[TW-1:0];
        kpec_pkg::REG_REPEAT_START:    repeat_start    <= pwdata[TW-1:0];
        kpec_pkg::REG_REPEAT_INTERVAL: repeat_interval <= pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      kpec_pkg::REG_SHORT_HOLD:      prdata = 32'(short_hold);
      kpec_pkg::REG_LONG_HOLD:       prdata = 32'(long_hold);
      kpec_pkg::REG_REPEAT_START:    prdata = 32'(repeat_start);
      kpec_pkg::REG_REPEAT_INTERVAL: prdata = 32'(repeat_interval);
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      levels   <= levels_in;
      inj_code <= inj_in;
    end
  end

  // Next record and up to three events for the key under evaluation.
  logic          n_was, n_sd, n_ld;
  logic [TW-1:0] n_hold, n_rc;
  logic [kpec_pkg::PEND_SLOTS-1:0] e_valid;
  logic [CW-1:0] e_code[kpec_pkg::PEND_SLOTS];
  logic          k_was, k_sd, k_ld;
  logic [TW-1:0] k_hold, k_rc;

  always_comb begin
    k_was  = was_pressed[cmd.key];
    k_hold = hold_count[cmd.key];
    k_sd   = short_done[cmd.key];
    k_ld   = long_done[cmd.key];
    k_rc   = repeat_count[cmd.key];
    n_was  = k_was;
    n_hold = k_hold;
    n_sd   = k_sd;
    n_ld   = k_ld;
    n_rc   = k_rc;
    e_valid = '0;
    for (int i = 0; i < kpec_pkg::PEND_SLOTS; i++) begin
      e_code[i] = '0;
    end
    if (levels[cmd.key]) begin
      if (!k_was) begin
        n_hold = TW'(1);
        n_sd   = 1'b0;
        n_ld   = 1'b0;
        n_rc   = '0;
      end else begin
        n_hold = kpec_pkg::sat_inc(k_hold);
      end
      n_was = 1'b1;
      if (!n_sd && n_hold >= short_hold && cmd.key != kpec_pkg::KEY_BACK) begin
        e_valid[0] = 1'b1;
        case (cmd.key)
          kpec_pkg::KEY_SET: e_code[0] = kpec_pkg::EV_SET;
          kpec_pkg::KEY_UP:  e_code[0] = kpec_pkg::EV_UP;
          default:           e_code[0] = kpec_pkg::EV_DOWN;
        endcase
        n_sd = 1'b1;
      end
      if ((cmd.key == kpec_pkg::KEY_SET || cmd.key == kpec_pkg::KEY_DOWN) &&
          !n_ld && n_hold >= long_hold) begin
        e_valid[1] = 1'b1;
        e_code[1]  = (cmd.key == kpec_pkg::KEY_SET) ? kpec_pkg::EV_SET_LONG
                                                    : kpec_pkg::EV_BACK;
        n_ld = 1'b1;
      end
      // Down stops repeating once its long hold has turned into back.
      if (((cmd.key == kpec_pkg::KEY_DOWN && !n_ld) || cmd.key == kpec_pkg::KEY_UP) &&
          n_hold >= repeat_start) begin
        n_rc = kpec_pkg::sat_inc(n_rc);
        if (n_rc >= repeat_interval) begin
          e_valid[2] = 1'b1;
          e_code[2]  = (cmd.key == kpec_pkg::KEY_DOWN) ? kpec_pkg::EV_DOWN_REPEAT
                                                       : kpec_pkg::EV_UP_REPEAT;
          n_rc = '0;
        end
      end
    end else if (k_was) begin
      case (cmd.key)
        kpec_pkg::KEY_SET: begin
          e_valid[0] = !k_ld && !k_sd;
          e_code[0]  = kpec_pkg::EV_SET;
        end
        kpec_pkg::KEY_UP: begin
          e_valid[0] = !k_sd;
          e_code[0]  = kpec_pkg::EV_UP;
        end
        kpec_pkg::KEY_DOWN: begin
          e_valid[0] = !k_ld && !k_sd;
          e_code[0]  = kpec_pkg::EV_DOWN;
        end
        default: begin
          e_valid[0] = 1'b1;
          e_code[0]  = kpec_pkg::EV_BACK;
        end
      endcase
      n_was  = 1'b0;
      n_hold = '0;
      n_sd   = 1'b0;
      n_ld   = 1'b0;
      n_rc   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < kpec_pkg::NUM_KEYS; k++) begin
        was_pressed[k]  <= 1'b0;
        hold_count[k]   <= '0;
        short_done[k]   <= 1'b0;
        long_done[k]    <= 1'b0;
        repeat_count[k] <= '0;
      end
    end else if (cmd.eval) begin
      was_pressed[cmd.key]  <= n_was;
      hold_count[cmd.key]   <= n_hold;
      short_done[cmd.key]   <= n_sd;
      long_done[cmd.key]    <= n_ld;
      repeat_count[cmd.key] <= n_rc;
    end
  end

  // Pending slots drain lowest first, which keeps the event order of a key.
  logic [CW-1:0]                   sel_code;
  logic [kpec_pkg::PEND_SLOTS-1:0] sel_mask;

  always_comb begin
    sel_code = pend_code[2];
    sel_mask = 3'b100;
    if (pend_valid[0]) begin
      sel_code = pend_code[0];
      sel_mask = 3'b001;
    end else if (pend_valid[1]) begin
      sel_code = pend_code[1];
      sel_mask = 3'b010;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= '0;
    end else if (cmd.eval) begin
      pend_valid <= e_valid;
    end else if (cmd.push_pend) begin
      pend_valid <= pend_valid & ~sel_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      for (int i = 0; i < kpec_pkg::PEND_SLOTS; i++) begin
        pend_code[i] <= e_code[i];
      end
    end
  end

  // Event ring: one slot is kept free, and a push into a full ring drops the
  // oldest word.
  logic          push;
  logic [CW-1:0] push_code;
  logic [AW-1:0] wr_pos_next, rd_pos_inc;
  logic          ring_empty;
  logic [NW-1:0] count;

  assign push        = cmd.push_pend || cmd.push_inj;
  assign push_code   = cmd.push_inj ? inj_code : sel_code;
  assign wr_pos_next = (wr_pos == AW'(kpec_pkg::RING_DEPTH - 1)) ? '0 : wr_pos + 1'b1;
  assign rd_pos_inc  = (rd_pos == AW'(kpec_pkg::RING_DEPTH - 1)) ? '0 : rd_pos + 1'b1;
  assign ring_empty  = (wr_pos == rd_pos);
  assign count = (wr_pos >= rd_pos) ? ({1'b0, wr_pos} - {1'b0, rd_pos})
               : ({1'b0, wr_pos} + NW'(kpec_pkg::RING_DEPTH) - {1'b0, rd_pos});

  always_ff @(posedge clk) begin
    if (push) begin
      ring_mem[wr_pos] <= push_code;
    end
    if (cmd.pop_rd) begin
      rd_data <= ring_mem[rd_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos    <= '0;
      rd_pos    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        res_valid <= 1'b0;
      end
      if (push) begin
        wr_pos <= wr_pos_next;
        if (wr_pos_next == rd_pos) begin
          rd_pos <= rd_pos_inc;
        end
      end else if (cmd.pop_rd && !ring_empty) begin
        rd_pos    <= rd_pos_inc;
        res_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_event_valid <= res_valid;
      out_event_code  <= res_valid ? rd_data : '0;
      out_queue_count <= 3'(count);
    end
  end

  assign sts.pend_any = |pend_valid;

endmodule

/* rtl/key_press_event_classifier.sv */
`timescale 1ns / 1ps
// An undefined operation goes straight to the output step; a pop or an inject first
// reads from or writes to the ring, and a poll tick evaluates each key in turn and
// pushes its events one by one through the single ring write port.
// One word is in work at a time; the next is accepted once the result has moved to
// the output register, at the earliest in the cycle after. Reset (rst, synchronous)
// clears key records, ring pointers and handshakes and restores the register defaults.
module key_press_event_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // key_levels[3:0], inject_code[6:4], zero [7]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // event_code[2:0], queue_count[5:3], zero [7:6]
  output logic [0:0]  m_tuser,   // event_valid[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  kpec_pkg::kpec_cmd_t cmd;
  kpec_pkg::kpec_sts_t sts;
  logic                          ev_valid;
  logic [kpec_pkg::CODE_W-1:0]   ev_code;
  logic [2:0]                    q_count;

  assign pready  = 1'b1;
  assign m_tdata = {2'b00, q_count, ev_code};
  assign m_tuser = ev_valid;

  kpec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op_in    (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kpec_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .levels_in       (s_tdata[3:0]),
    .inj_in          (s_tdata[6:4]),
    .out_event_valid (ev_valid),
    .out_event_code  (ev_code),
    .out_queue_count (q_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
  );

endmodule

/* rtl/kpec_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the key press event classifier, bound to the top level.
// Depends only on the top level's ports.
module kpec_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [0:0]  m_tuser,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // No result word may be shown straight after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word shown after reset");

  // The block works on one word at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word accepted while one is in work");

  // A result without an event carries code zero.
  a_empty_code: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[2:0] == 3'd0))
    else $error("non-zero code without an event");

  // A popped event leaves at most six words in the ring.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[5:3] != 3'd7))
    else $error("queue count too high after a pop");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result word changed");

endmodule

bind key_press_event_classifier kpec_checker u_kpec_checker (.*);

/* dv/tb_key_press_event_classifier.sv */
`timescale 1ns / 1ps
// Self-checking testbench for key_press_event_classifier: stream words in, event
// reports out, timings set over APB. Depends on kpec_pkg and the block's RTL only.
module tb_key_press_event_classifier;

  localparam logic [1:0] OP_UNDEFINED = 2'd3;

  typedef struct packed {
    logic [1:0]                  op;
    logic [3:0]                  levels;
    logic [kpec_pkg::CODE_W-1:0] inj;
  } key_word_t;

  typedef struct packed {
    logic                        valid;
    logic [kpec_pkg::CODE_W-1:0] code;
    logic [2:0]                  count;
  } event_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;    // key_levels[3:0], inject_code[6:4], zero [7]
  logic [1:0]  s_tuser = 2'd0;    // operation[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // event_code[2:0], queue_count[5:3], zero [7:6]
  logic [0:0]  m_tuser;           // event_valid[0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  key_press_event_classifier dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Our own copy of the key records, the ring and the timing registers.
  logic [kpec_pkg::TICK_W-1:0] tick_cfg [4] = '{kpec_pkg::SHORT_HOLD_RESET,
                                                kpec_pkg::LONG_HOLD_RESET,
                                                kpec_pkg::REPEAT_START_RESET,
                                                kpec_pkg::REPEAT_INTERVAL_RESET};
  logic                        pressed     [kpec_pkg::NUM_KEYS] = '{default: 1'b0};
  logic [kpec_pkg::TICK_W-1:0] held_for    [kpec_pkg::NUM_KEYS] = '{default: '0};
  logic                        click_sent  [kpec_pkg::NUM_KEYS] = '{default: 1'b0};
  logic                        long_sent   [kpec_pkg::NUM_KEYS] = '{default: 1'b0};
  logic [kpec_pkg::TICK_W-1:0] repeat_wait [kpec_pkg::NUM_KEYS] = '{default: '0};
  logic [kpec_pkg::CODE_W-1:0] ring_slots  [kpec_pkg::RING_DEPTH] = '{default: '0};
  int                ring_wr = 0;
  int                ring_rd = 0;

  key_word_t     input_words[$];
  event_report_t awaited_reports[$];
  int            planned_words = 0;
  int            mismatches = 0;
  int            src_idle = 0;
  int            sink_idle = 0;
  bit            steady = 1'b0;

  function automatic void ring_push(input logic [kpec_pkg::CODE_W-1:0] code);
    int nxt;
    nxt = (ring_wr + 1) % kpec_pkg::RING_DEPTH;
    // A full ring loses its oldest event.
    if (nxt == ring_rd) ring_rd = (ring_rd + 1) % kpec_pkg::RING_DEPTH;
    ring_slots[ring_wr] = code;
    ring_wr = nxt;
  endfunction

  function automatic void forget_key(input int k);
    pressed[k]     = 1'b0;
    held_for[k]    = '0;
    click_sent[k]  = 1'b0;
    long_sent[k]   = 1'b0;
    repeat_wait[k] = '0;
  endfunction

  function automatic void repeat_step(input int k, input logic [kpec_pkg::CODE_W-1:0] code);
    if (repeat_wait[k] != '1) repeat_wait[k]++;
    if (repeat_wait[k] >= tick_cfg[kpec_pkg::REG_REPEAT_INTERVAL]) begin
      ring_push(code);
      repeat_wait[k] = '0;
    end
  endfunction

  function automatic void press_tick(input int k);
    if (!pressed[k]) begin
      forget_key(k);
      pressed[k]  = 1'b1;
      held_for[k] = 8'd1;
    end else if (held_for[k] != '1) begin
      held_for[k]++;
    end
    if (!click_sent[k] && held_for[k] >= tick_cfg[kpec_pkg::REG_SHORT_HOLD] &&
        k != kpec_pkg::KEY_BACK) begin
      ring_push(k == kpec_pkg::KEY_SET ? kpec_pkg::EV_SET :
                (k == kpec_pkg::KEY_UP ? kpec_pkg::EV_UP : kpec_pkg::EV_DOWN));
      click_sent[k] = 1'b1;
    end
    case (k)
      kpec_pkg::KEY_SET: begin
        if (!long_sent[k] && held_for[k] >= tick_cfg[kpec_pkg::REG_LONG_HOLD]) begin
          ring_push(kpec_pkg::EV_SET_LONG);
          long_sent[k] = 1'b1;
        end
      end
      kpec_pkg::KEY_DOWN: begin
        // A long hold of down stands for back and ends its auto-repeat.
        if (!long_sent[k] && held_for[k] >= tick_cfg[kpec_pkg::REG_LONG_HOLD]) begin
          ring_push(kpec_pkg::EV_BACK);
          long_sent[k] = 1'b1;
        end
        if (!long_sent[k] && held_for[k] >= tick_cfg[kpec_pkg::REG_REPEAT_START])
          repeat_step(k, kpec_pkg::EV_DOWN_REPEAT);
      end
      kpec_pkg::KEY_UP: begin
        if (held_for[k] >= tick_cfg[kpec_pkg::REG_REPEAT_START])
          repeat_step(k, kpec_pkg::EV_UP_REPEAT);
      end
      default: ;
    endcase
  endfunction

  function automatic void release_tick(input int k);
    if (pressed[k]) begin
      case (k)
        kpec_pkg::KEY_SET:  if (!long_sent[k] && !click_sent[k]) ring_push(kpec_pkg::EV_SET);
        kpec_pkg::KEY_UP:   if (!click_sent[k]) ring_push(kpec_pkg::EV_UP);
        kpec_pkg::KEY_DOWN: if (!long_sent[k] && !click_sent[k]) ring_push(kpec_pkg::EV_DOWN);
        default:            ring_push(kpec_pkg::EV_BACK);
      endcase
      forget_key(k);
    end
  endfunction

  function automatic event_report_t classify_word(input logic [1:0] op,
                                                  input logic [3:0] levels,
                                                  input logic [kpec_pkg::CODE_W-1:0] inj);
    event_report_t r;
    int k;
    r = '0;
    case (op)
      kpec_pkg::OP_TICK: begin
        for (k = 0; k < kpec_pkg::NUM_KEYS; k++) begin
          if (levels[k]) press_tick(k);
          else release_tick(k);
        end
      end
      kpec_pkg::OP_POP: begin
        if (ring_rd != ring_wr) begin
          r.valid = 1'b1;
          r.code  = ring_slots[ring_rd];
          ring_rd = (ring_rd + 1) % kpec_pkg::RING_DEPTH;
        end
      end
      kpec_pkg::OP_INJECT: ring_push(inj);
      default: ;
    endcase
    r.count = 3'((ring_wr + kpec_pkg::RING_DEPTH - ring_rd) % kpec_pkg::RING_DEPTH);
    return r;
  endfunction

  function automatic void add_word(input logic [1:0] op, input logic [3:0] levels,
                                   input logic [kpec_pkg::CODE_W-1:0] inj);
    key_word_t w;
    w.op = op;
    w.levels = levels;
    w.inj = inj;
    input_words.push_back(w);
    if (op != OP_UNDEFINED) planned_words++;
  endfunction

  task automatic note_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    mismatches++;
    $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
  endtask

  // Source side: one word at a time from the queue, with random bursts of idling.
  always @(posedge clk) begin
    key_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        awaited_reports.push_back(classify_word(s_tuser, s_tdata[3:0], s_tdata[6:4]));
      if (!s_tvalid || s_tready) begin
        if (src_idle == 0 && !steady && $urandom_range(0, 11) == 0)
          src_idle = $urandom_range(1, 10);
        if (src_idle != 0 || input_words.size() == 0) begin
          if (src_idle != 0) src_idle--;
          s_tvalid <= 1'b0;
        end else begin
          w = input_words.pop_front();
          s_tuser  <= w.op;
          s_tdata  <= {1'b0, w.inj, w.levels};
          s_tvalid <= 1'b1;
        end
      end
    end
  end

  // Sink side: checks every report word and stalls in random bursts.
  always @(posedge clk) begin
    event_report_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_reports.size() == 0) begin
          note_mismatch("unawaited word", m_tdata, 8'd0);
        end else begin
          want = awaited_reports.pop_front();
          if (m_tuser[0] !== want.valid)
            note_mismatch("event_valid", 8'(m_tuser[0]), 8'(want.valid));
          if (m_tdata[2:0] !== want.code)
            note_mismatch("event_code", 8'(m_tdata[2:0]), 8'(want.code));
          if (m_tdata[5:3] !== want.count)
            note_mismatch("queue_count", 8'(m_tdata[5:3]), 8'(want.count));
        end
      end
      if (sink_idle == 0 && !steady && $urandom_range(0, 9) == 0)
        sink_idle = $urandom_range(1, 10);
      if (sink_idle != 0) begin
        sink_idle--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [kpec_pkg::TICK_W-1:0] val);
    logic [23:0] junk;
    junk = 24'($urandom);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tick_cfg[idx] = val;
  endtask

  task automatic set_timing(input logic [kpec_pkg::TICK_W-1:0] short_hold,
                            input logic [kpec_pkg::TICK_W-1:0] long_hold,
                            input logic [kpec_pkg::TICK_W-1:0] rep_start,
                            input logic [kpec_pkg::TICK_W-1:0] rep_gap);
    apb_write(kpec_pkg::REG_SHORT_HOLD, short_hold);
    apb_write(kpec_pkg::REG_LONG_HOLD, long_hold);
    apb_write(kpec_pkg::REG_REPEAT_START, rep_start);
    apb_write(kpec_pkg::REG_REPEAT_INTERVAL, rep_gap);
  endtask

  // Waits until every queued word has gone in and its report has come back.
  task automatic drain();
    do @(negedge clk);
    while (input_words.size() != 0 || s_tvalid || awaited_reports.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Press-hold-release gestures with random content, plus pops, injects and noise.
  task automatic plan_gestures(input int target);
    int stop_at;
    int len;
    int i;
    logic [3:0] keys;
    stop_at = planned_words + target;
    while (planned_words < stop_at) begin
      if ($urandom_range(0, 1)) keys = 4'b0001 << $urandom_range(0, 3);
      else keys = 4'($urandom_range(1, 15));
      case ($urandom_range(0, 9))
        0, 1:    len = $urandom_range(1, 3);
        9:       len = $urandom_range(1, 60);
        default: len = $urandom_range(1, 24);
      endcase
      for (i = 0; i < len; i++) begin
        // Now and then a key bounces mid-gesture.
        if ($urandom_range(0, 15) == 0) keys = keys ^ (4'b0001 << $urandom_range(0, 3));
        add_word(kpec_pkg::OP_TICK, keys, 3'($urandom));
        if ($urandom_range(0, 5) == 0) add_word(kpec_pkg::OP_POP, 4'($urandom), 3'($urandom));
      end
      if ($urandom_range(0, 4) == 0)
        add_word(kpec_pkg::OP_TICK, keys & 4'($urandom), 3'($urandom));
      add_word(kpec_pkg::OP_TICK, 4'b0000, 3'($urandom));
      repeat ($urandom_range(0, 4)) add_word(kpec_pkg::OP_POP, 4'($urandom), 3'($urandom));
      if ($urandom_range(0, 9) == 0)
        add_word(kpec_pkg::OP_INJECT, 4'($urandom), 3'($urandom));
      if ($urandom_range(0, 24) == 0) add_word(OP_UNDEFINED, 4'($urandom), 3'($urandom));
    end
  endtask

  initial begin
    int i;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed opening at the reset timings.
    add_word(kpec_pkg::OP_POP, 4'hF, 3'd7);
    add_word(OP_UNDEFINED, 4'hF, 3'd7);
    add_word(kpec_pkg::OP_INJECT, 4'h0, 3'd7);
    for (i = 0; i < 7; i++) add_word(kpec_pkg::OP_INJECT, 4'h0, 3'(i));
    add_word(kpec_pkg::OP_POP, 4'h0, 3'd0);
    add_word(kpec_pkg::OP_POP, 4'h0, 3'd0);
    for (i = 0; i < 6; i++) add_word(kpec_pkg::OP_TICK, 4'hF, 3'd0);
    add_word(kpec_pkg::OP_TICK, 4'h0, 3'd0);
    add_word(kpec_pkg::OP_TICK, 4'h2, 3'd0);
    add_word(kpec_pkg::OP_TICK, 4'h0, 3'd0);
    add_word(kpec_pkg::OP_TICK, 4'h4, 3'd0);
    add_word(kpec_pkg::OP_TICK, 4'h0, 3'd0);
    add_word(kpec_pkg::OP_POP, 4'h0, 3'd0);
    add_word(kpec_pkg::OP_POP, 4'h0, 3'd0);
    plan_gestures(300);
    drain();

    set_timing(8'd1, 8'd1, 8'd1, 8'd1);
    plan_gestures(300);
    drain();

    // Top thresholds need a hold long enough to saturate the counters.
    set_timing(8'd255, 8'd255, 8'd255, 8'd255);
    for (i = 0; i < 262; i++) add_word(kpec_pkg::OP_TICK, 4'hF, 3'($urandom));
    add_word(kpec_pkg::OP_TICK, 4'h0, 3'd0);
    repeat (8) add_word(kpec_pkg::OP_POP, 4'h0, 3'd0);
    plan_gestures(80);
    drain();

    set_timing(8'd0, 8'd0, 8'd0, 8'd0);
    plan_gestures(250);
    drain();

    set_timing(8'($urandom_range(1, 20)), 8'($urandom_range(1, 20)),
               8'($urandom_range(1, 20)), 8'($urandom_range(1, 20)));
    plan_gestures(300);
    drain();

    set_timing(8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
               8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)));
    steady = 1'b1;
    plan_gestures(300);
    drain();
    repeat (30) @(posedge clk);

    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

/* files.f */
rtl/kpec_pkg.sv
rtl/kpec_ctrl.sv
rtl/kpec_dp.sv
rtl/key_press_event_classifier.sv
rtl/kpec_checker.sv
dv/tb_key_press_event_classifier.sv
